// ===== rtl/encoder_position_velocity_accumulator_top_defines.svh =====
`ifndef ENCODER_POSITION_VELOCITY_ACCUMULATOR_TOP_DEFINES_SVH
`define ENCODER_POSITION_VELOCITY_ACCUMULATOR_TOP_DEFINES_SVH

// clocked check, held off during reset
`define EPVA_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// clocked check that also holds during reset
`define EPVA_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/epva_pkg.sv =====
`timescale 1ns / 1ps
package epva_pkg;

	// func codes
	localparam logic [1:0] FUNC_UPDATE     = 2'd0;
	localparam logic [1:0] FUNC_RESEED     = 2'd1;
	localparam logic [1:0] FUNC_SET_POS    = 2'd2;
	localparam logic [1:0] FUNC_INVALIDATE = 2'd3;

	// status codes
	localparam logic [1:0] STAT_OK        = 2'd0;
	localparam logic [1:0] STAT_LIMIT     = 2'd1;
	localparam logic [1:0] STAT_NO_COUNT  = 2'd2;
	localparam logic [1:0] STAT_INVALID   = 2'd3;

	// register indexes
	localparam logic [7:0] REG_COUNTER_WIDTH    = 8'd0;
	localparam logic [7:0] REG_INVERT_DIRECTION = 8'd1;
	localparam logic [7:0] REG_TIMER_HZ         = 8'd2;
	localparam logic [7:0] REG_POSITION_LIMIT   = 8'd3;

	localparam logic [19:0] MICROS_PER_SECOND = 20'd1000000;
	localparam int DIV_W = 52;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV1,
		ST_MUL2,
		ST_DIV2,
		ST_SAT,
		ST_FIN
	} epva_state_t;

endpackage

// ===== rtl/encoder_position_velocity_accumulator_top.sv =====
`timescale 1ns / 1ps
// sequence: reseed, set position, invalidate and updates without velocity go from the
// accepting edge to ST_FIN; an update whose interval is zero passes ST_DIV1 and ST_MUL2
// first, one with velocity ST_DIV1, ST_MUL2, ST_DIV2 and ST_SAT; ST_FIN waits under stall
// throughput: one item at a time, no new item is taken until the result is loaded; the
// bit-serial divider runs 52 steps for the interval and 52 more for the velocity
// reset: asynchronous active low, clears count state and loads register defaults
module encoder_position_velocity_accumulator_top
	import epva_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [7:0]         cfg_index,
	input  logic [62:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         func,
	input  logic [31:0]        raw_reading,
	input  logic [31:0]        timestamp,
	input  logic signed [63:0] operand_value,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         status,
	output logic signed [63:0] position,
	output logic signed [31:0] velocity,
	output logic [31:0]        elapsed_us,
	output logic               velocity_valid
);

	// configuration
	logic [5:0]  counter_width_q;
	logic        invert_q;
	logic [31:0] timer_hz_q;
	logic [62:0] limit_q;

	// count state
	logic        count_valid_q;
	logic        have_last_q;
	logic [31:0] last_raw_q;
	logic [63:0] accum_q;
	logic [63:0] bias_q;
	logic [31:0] last_time_q;

	// per-item work registers
	logic signed [33:0] delta_q;
	logic [1:0]         res_status_q;
	logic [31:0]        res_vel_q;
	logic [31:0]        res_ivl_q;
	logic               res_vv_q;

	// bit-serial divider
	logic [32:0]      div_rem_q;
	logic [DIV_W-1:0] div_quo_q;
	logic [31:0]      div_den_q;
	logic [5:0]       div_cnt_q;

	logic out_valid_q;
	epva_state_t state_q, state_d;

	logic accept, div_step, div_last, fin_load, ivl_zero;

	assign accept   = in_valid && (state_q == ST_IDLE);
	assign div_last = (div_cnt_q == 6'(DIV_W - 1));
	assign ivl_zero = (div_quo_q[31:0] == 32'd0);

	// effective width, mask and half span
	logic [5:0]  eff_w;
	logic [31:0] mask;
	logic [32:0] half;
	logic [32:0] diff;
	logic signed [33:0] d_raw, delta;

	always_comb begin
		if (counter_width_q == 6'd0) begin
			eff_w = 6'd1;
		end else if (counter_width_q > 6'd32) begin
			eff_w = 6'd32;
		end else begin
			eff_w = counter_width_q;
		end
		mask  = 32'hFFFF_FFFF >> (6'd32 - eff_w);
		half  = 33'd1 << (eff_w - 6'd1);
		diff  = {1'b0, (raw_reading - last_raw_q) & mask};
		if (diff > half) begin
			d_raw = $signed({1'b0, diff}) - $signed({half, 1'b0});
		end else begin
			d_raw = $signed({1'b0, diff});
		end
		delta = invert_q ? -d_raw : d_raw;
	end

	// interval numerator and set-position check
	logic [31:0]      cyc;
	logic [DIV_W-1:0] ivl_num;
	logic [63:0]      opnd_mag;
	logic             out_of_limit;
	logic [31:0]      hz_eff;

	assign cyc          = timestamp - last_time_q;
	assign ivl_num      = DIV_W'(cyc * MICROS_PER_SECOND);
	assign hz_eff       = (timer_hz_q == 32'd0) ? 32'd1 : timer_hz_q;
	assign opnd_mag     = operand_value[63] ? (64'd0 - operand_value) : operand_value;
	assign out_of_limit = opnd_mag > {1'b0, limit_q};

	// velocity numerator from delta magnitude
	logic             delta_neg;
	logic [31:0]      delta_mag;
	logic [DIV_W-1:0] vel_num;

	assign delta_neg = delta_q[33];
	assign delta_mag = delta_neg ? 32'(-delta_q) : delta_q[31:0];
	assign vel_num   = DIV_W'(delta_mag * MICROS_PER_SECOND);

	// one restoring step
	logic [32:0] rem_sh;
	logic [33:0] rem_sub;
	logic        rem_ge;

	assign rem_sh  = {div_rem_q[31:0], div_quo_q[DIV_W-1]};
	assign rem_sub = {1'b0, rem_sh} - {2'b00, div_den_q};
	assign rem_ge  = !rem_sub[33];

	// saturation of the velocity quotient
	logic [31:0] vel_sat;

	always_comb begin
		if (delta_neg) begin
			vel_sat = (div_quo_q > DIV_W'(33'h0_8000_0000)) ? 32'h8000_0000
				: (32'd0 - div_quo_q[31:0]);
		end else begin
			vel_sat = (div_quo_q > DIV_W'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF
				: div_quo_q[31:0];
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (func == FUNC_UPDATE && count_valid_q && have_last_q) begin
						state_d = ST_DIV1;
					end else begin
						state_d = ST_FIN;
					end
				end
			end
			ST_DIV1: if (div_last) state_d = ST_MUL2;
			ST_MUL2: state_d = ivl_zero ? ST_FIN : ST_DIV2;
			ST_DIV2: if (div_last) state_d = ST_SAT;
			ST_SAT:  state_d = ST_FIN;
			ST_FIN:  if (!out_valid_q || !out_stall) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		in_stall = 1'b1;
		div_step = 1'b0;
		fin_load = 1'b0;
		unique case (state_q)
			ST_IDLE: in_stall = 1'b0;
			ST_DIV1, ST_DIV2: div_step = 1'b1;
			ST_FIN:  fin_load = !out_valid_q || !out_stall;
			default: ;
		endcase
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			counter_width_q <= 6'd32;
			invert_q        <= 1'b0;
			timer_hz_q      <= 32'd1000000;
			limit_q         <= 63'h4000_0000_0000_0000;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_COUNTER_WIDTH:    counter_width_q <= cfg_data[5:0];
				REG_INVERT_DIRECTION: invert_q        <= cfg_data[0];
				REG_TIMER_HZ:         timer_hz_q      <= cfg_data[31:0];
				REG_POSITION_LIMIT:   limit_q         <= cfg_data;
				default: ;
			endcase
		end
	end

	// count state and item work
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			count_valid_q <= 1'b0;
			have_last_q   <= 1'b0;
			last_raw_q    <= '0;
			accum_q       <= '0;
			bias_q        <= '0;
			last_time_q   <= '0;
			div_cnt_q     <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				res_status_q <= STAT_OK;
				res_vel_q    <= '0;
				res_ivl_q    <= '0;
				res_vv_q     <= 1'b0;
				div_rem_q    <= '0;
				div_quo_q    <= ivl_num;
				div_den_q    <= hz_eff;
				div_cnt_q    <= '0;
				unique case (func)
					FUNC_UPDATE: begin
						if (!count_valid_q) begin
							res_status_q <= STAT_INVALID;
						end else begin
							delta_q     <= delta;
							last_raw_q  <= raw_reading & mask;
							accum_q     <= accum_q + 64'(delta);
							last_time_q <= timestamp;
							have_last_q <= 1'b1;
						end
					end
					FUNC_RESEED: begin
						accum_q       <= operand_value;
						bias_q        <= '0;
						last_raw_q    <= raw_reading & mask;
						count_valid_q <= 1'b1;
						have_last_q   <= 1'b0;
					end
					FUNC_SET_POS: begin
						if (out_of_limit) begin
							res_status_q <= STAT_LIMIT;
						end else if (!count_valid_q) begin
							res_status_q <= STAT_NO_COUNT;
						end else begin
							bias_q <= operand_value - accum_q;
						end
					end
					FUNC_INVALIDATE: count_valid_q <= 1'b0;
					default: ;
				endcase
			end
			if (div_step) begin
				div_rem_q <= rem_ge ? rem_sub[32:0] : rem_sh;
				div_quo_q <= {div_quo_q[DIV_W-2:0], rem_ge};
				div_cnt_q <= div_cnt_q + 6'd1;
			end
			// second division: velocity numerator over interval
			if (state_q == ST_MUL2 && !ivl_zero) begin
				res_ivl_q <= div_quo_q[31:0];
				div_den_q <= div_quo_q[31:0];
				div_quo_q <= vel_num;
				div_rem_q <= '0;
				div_cnt_q <= '0;
			end
			if (state_q == ST_SAT) begin
				res_vel_q <= vel_sat;
				res_vv_q  <= 1'b1;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_load) begin
			status         <= res_status_q;
			position       <= accum_q + bias_q;
			velocity       <= res_vel_q;
			elapsed_us     <= res_ivl_q;
			velocity_valid <= res_vv_q;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== rtl/epva_checker.sv =====
`timescale 1ns / 1ps
`include "encoder_position_velocity_accumulator_top_defines.svh"
module epva_checker
	import epva_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_stall,
	input logic [1:0]         status,
	input logic signed [63:0] position,
	input logic signed [31:0] velocity,
	input logic [31:0]        elapsed_us,
	input logic               velocity_valid
);

	// a stalled result beat holds
	`EPVA_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(position) && $stable(status), "result beat changed under stall")

	// velocity only comes with a good status
	`EPVA_ASSERT(a_vv_ok, out_valid && velocity_valid |-> status == STAT_OK, "velocity with bad status")

	// no velocity means zero fields
	`EPVA_ASSERT(a_vv_zero, out_valid && !velocity_valid |-> velocity == 32'sd0 && elapsed_us == 32'd0, "stale velocity fields")

	// a computed velocity has a nonzero interval
	`EPVA_ASSERT(a_ivl_nz, out_valid && velocity_valid |-> elapsed_us != 32'd0, "zero interval with velocity")

	// no result beat during reset
	`EPVA_ASSERT_ALWAYS(a_rst_idle, !arst_n |-> !out_valid, "result beat during reset")

endmodule

bind encoder_position_velocity_accumulator_top epva_checker u_epva_checker (.*);
